// File: hw/rtl/idte_pkg.sv
`timescale 1ns / 1ps

package idte_pkg;

	// ASCII codes used by the format check
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] DATE_LEN = 8'd10;

	// Year bias of three 400-year eras keeps the shifted year non-negative
	localparam logic signed [14:0] YEAR_BIAS = 15'sd1200;
	// 719468 plus three eras of 146097 days
	localparam logic [23:0] DAY_BIAS = 24'd1157759;
	// floor(x / 25) == (x * 1311) >> 15 for x below 2800
	localparam logic [10:0] RECIP_25 = 11'd1311;
	localparam int RECIP_SHIFT = 15;
	// 86400e9 = 1318359375 << 16
	localparam logic [30:0] NANOS_K = 31'd1318359375;
	localparam int NANOS_SHIFT = 16;
	localparam logic signed [22:0] MAX_SAFE_DAYS = 23'sd106751;

	// Ten characters of the date text plus its length
	typedef struct packed {
		logic [7:0] text_length;
		logic [7:0] char_0;
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
		logic [7:0] char_5;
		logic [7:0] char_6;
		logic [7:0] char_7;
		logic [7:0] char_8;
		logic [7:0] char_9;
	} idte_text_t;

	// Parser result: format status, biased year, day of year from March 1
	typedef struct packed {
		logic        ok;
		logic [13:0] yy;
		logic [8:0]  doy;
	} idte_parse_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// First day of each month in a March-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/idte_in_if.sv
`timescale 1ns / 1ps

interface idte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_length;
	logic [7:0] char_0;
	logic [7:0] char_1;
	logic [7:0] char_2;
	logic [7:0] char_3;
	logic [7:0] char_4;
	logic [7:0] char_5;
	logic [7:0] char_6;
	logic [7:0] char_7;
	logic [7:0] char_8;
	logic [7:0] char_9;

	modport source (
		output valid, text_length, char_0, char_1, char_2, char_3, char_4,
		       char_5, char_6, char_7, char_8, char_9,
		input  ready
	);

	modport sink (
		input  valid, text_length, char_0, char_1, char_2, char_3, char_4,
		       char_5, char_6, char_7, char_8, char_9,
		output ready
	);
endinterface

// File: hw/rtl/idte_out_if.sv
`timescale 1ns / 1ps

interface idte_out_if;
	logic               valid;
	logic               ready;
	logic               valid_res;
	logic signed [22:0] day_number;
	logic signed [63:0] epoch_nanos;
	logic               overflow;

	modport source (
		output valid, valid_res, day_number, epoch_nanos, overflow,
		input  ready
	);

	modport sink (
		input  valid, valid_res, day_number, epoch_nanos, overflow,
		output ready
	);
endinterface

// File: hw/rtl/idte_parse.sv
`timescale 1ns / 1ps

module idte_parse
	import idte_pkg::*;
(
	input  idte_text_t  text,
	output idte_parse_t res
);

	logic [3:0]         d0, d1, d2, d3, d5, d6, d8, d9;
	logic               year_neg;
	logic               fmt_ok;
	logic [9:0]         year_mag;
	logic signed [14:0] year_val;
	logic signed [14:0] year_adj;
	logic [6:0]         month;
	logic [6:0]         day;
	logic               early;
	logic [3:0]         mp;

	// Digit values are the low nibble once the character is known to be a digit
	assign d0 = text.char_0[3:0];
	assign d1 = text.char_1[3:0];
	assign d2 = text.char_2[3:0];
	assign d3 = text.char_3[3:0];
	assign d5 = text.char_5[3:0];
	assign d6 = text.char_6[3:0];
	assign d8 = text.char_8[3:0];
	assign d9 = text.char_9[3:0];

	assign year_neg = (text.char_0 == CH_DASH);

	// Strict YYYY-MM-DD layout; a minus sign may stand in place of the first year digit
	assign fmt_ok = (text.text_length == DATE_LEN)
		&& (text.char_4 == CH_DASH) && (text.char_7 == CH_DASH)
		&& (is_digit(text.char_0) || year_neg)
		&& is_digit(text.char_1) && is_digit(text.char_2) && is_digit(text.char_3)
		&& is_digit(text.char_5) && is_digit(text.char_6)
		&& is_digit(text.char_8) && is_digit(text.char_9);

	// Field values
	always_comb begin
		year_mag = 10'(d1) * 10'd100 + 10'(d2) * 10'd10 + 10'(d3);
		if (year_neg) begin
			year_val = -$signed({5'b0, year_mag});
		end else begin
			year_val = $signed({1'b0, 14'(d0) * 14'd1000 + {4'b0, year_mag}});
		end
		month = 7'(d5) * 7'd10 + 7'(d6);
		day   = 7'(d8) * 7'd10 + 7'(d9);
	end

	// January and February count with the previous year
	always_comb begin
		early    = (month <= 7'd2);
		year_adj = year_val - $signed({14'b0, early}) + YEAR_BIAS;
		mp       = early ? 4'(month + 7'd9) : 4'(month - 7'd3);
	end

	assign res.ok  = fmt_ok && (month >= 7'd1) && (month <= 7'd12)
		&& (day >= 7'd1) && (day <= 7'd31);
	assign res.yy  = year_adj[13:0];
	assign res.doy = month_start(mp) + 9'(day) - 9'd1;

endmodule

// File: hw/rtl/iso_date_to_epoch_nanos_top.sv
`timescale 1ns / 1ps
// An input transaction passes through stage registers s1, s2, s3 and s4 before its result reaches the output channel.
// Throughput: one date per cycle unless the output stalls; set by the four-stage pipeline that moves as one.
// A stall on the output holds every stage, and the input is not ready meanwhile.
// Reset (arst_n low, asynchronous) clears all stage valid bits; the
// pipeline is empty and ready right after reset.

module iso_date_to_epoch_nanos_top
	import idte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	idte_in_if.sink   date,
	idte_out_if.source stamp
);

	idte_text_t  text;
	idte_parse_t prs;
	logic        adv;

	// Stage registers
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               ok_s1, ok_s2, ok_s3;
	logic [13:0]        yy_s1;
	logic [8:0]         doy_s1, doy_s2;
	logic [11:0]        q4_s2;
	logic [6:0]         q100_s2;
	logic [4:0]         q400_s2;
	logic [21:0]        y365_s2;
	logic signed [22:0] days_s3;
	logic               valid_res_s4;
	logic signed [22:0] day_number_s4;
	logic signed [63:0] epoch_nanos_s4;
	logic               overflow_s4;

	// Combinational results per stage
	logic [11:0]        q4;
	logic [9:0]         q16;
	logic [22:0]        p100;
	logic [20:0]        p400;
	logic [22:0]        y365;
	logic [23:0]        sum3;
	logic signed [54:0] prod4;

	assign text = '{
		text_length: date.text_length,
		char_0: date.char_0, char_1: date.char_1, char_2: date.char_2,
		char_3: date.char_3, char_4: date.char_4, char_5: date.char_5,
		char_6: date.char_6, char_7: date.char_7, char_8: date.char_8,
		char_9: date.char_9
	};

	idte_parse u_parse (
		.text (text),
		.res  (prs)
	);

	// Whole pipeline advances unless a finished result is held
	assign adv        = !vld_s4 || stamp.ready;
	assign date.ready = adv;

	// Stage 2 math: leap-year terms and the 365-day product of the biased year
	always_comb begin
		q4   = yy_s1[13:2];
		q16  = yy_s1[13:4];
		p100 = 23'(q4) * 23'(RECIP_25);
		p400 = 21'(q16) * 21'(RECIP_25);
		y365 = 23'(yy_s1) * 23'd365;
	end

	// Stage 3 math: day count; fits 23 signed bits for every accepted date
	assign sum3 = 24'(y365_s2) + 24'(q4_s2) - 24'(q100_s2) + 24'(q400_s2)
		+ 24'(doy_s2) - DAY_BIAS;

	// Stage 4 math: days times the odd part of 86400e9
	assign prod4 = days_s3 * $signed({1'b0, NANOS_K});

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= date.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1  <= prs.ok;
			yy_s1  <= prs.yy;
			doy_s1 <= prs.doy;

			ok_s2   <= ok_s1;
			doy_s2  <= doy_s1;
			q4_s2   <= q4;
			q100_s2 <= p100[RECIP_SHIFT +: 7];
			q400_s2 <= p400[RECIP_SHIFT +: 5];
			y365_s2 <= y365[21:0];

			ok_s3   <= ok_s2;
			days_s3 <= ok_s2 ? $signed(sum3[22:0]) : 23'sd0;

			valid_res_s4   <= ok_s3;
			day_number_s4  <= days_s3;
			epoch_nanos_s4 <= {prod4[63 - NANOS_SHIFT:0], {NANOS_SHIFT{1'b0}}};
			overflow_s4    <= (days_s3 > MAX_SAFE_DAYS) || (days_s3 < -MAX_SAFE_DAYS);
		end
	end

	assign stamp.valid       = vld_s4;
	assign stamp.valid_res   = valid_res_s4;
	assign stamp.day_number  = day_number_s4;
	assign stamp.epoch_nanos = epoch_nanos_s4;
	assign stamp.overflow    = overflow_s4;

	// Rejected dates carry all-zero fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !valid_res_s4) |->
			(day_number_s4 == 23'sd0 && epoch_nanos_s4 == 64'sd0 && !overflow_s4))
		else $error("rejected date with nonzero fields");

	// Overflow is only flagged on a well-formed date
	a_ovf_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && overflow_s4) |-> valid_res_s4)
		else $error("overflow on rejected date");

	// A held result blocks the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !stamp.ready) |-> !date.ready)
		else $error("input ready during output stall");

	// Items move one stage on each advancing cycle
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && adv) |=> vld_s4)
		else $error("item lost between stages");

	// Accepted transaction reaches the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(date.valid && date.ready) |=> vld_s1)
		else $error("accepted transaction not captured");

endmodule

// File: bench/tb_iso_date_to_epoch_nanos_top.sv
`timescale 1ns / 1ps

module tb_iso_date_to_epoch_nanos_top
	import idte_pkg::*;
();

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic signed [63:0] NS_PER_DAY = 64'sd86400000000000;
	localparam longint SAFE_DAYS = 106751;

	// Expected output of one conversion
	typedef struct packed {
		logic               valid_res;
		logic signed [22:0] day_number;
		logic signed [63:0] epoch_nanos;
		logic               overflow;
	} epoch_result_t;

	logic clk;
	logic arst_n;

	idte_in_if  in_ch ();
	idte_out_if out_ch ();

	iso_date_to_epoch_nanos_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.date   (in_ch),
		.stamp  (out_ch)
	);

	epoch_result_t pending_conversions[$];
	bit idle_on;
	int stall_left;
	int cycle_count;
	int mismatch_count;
	int dates_sent;
	int results_checked;
	int valid_seen;
	int overflow_seen;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_conversions.size());
			$display("[iso_date_to_epoch_nanos_top] ERROR");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic longint numeral(input logic [7:0] c);
		return longint'(c) - 48;
	endfunction

	// Days since 1970-01-01 and nanoseconds for one date text
	function automatic epoch_result_t civil_epoch_of(input idte_text_t t);
		epoch_result_t r;
		logic [7:0] c [10];
		longint yr, mon, dd, era, yoe, mp, doy, doe, days;
		bit ok;
		r = '0;
		for (int i = 0; i < 10; i++)
			c[i] = t[79 - 8 * i -: 8];
		if (t.text_length != DATE_LEN || c[4] != CH_DASH || c[7] != CH_DASH)
			return r;
		ok = is_numeral(c[1]) && is_numeral(c[2]) && is_numeral(c[3]);
		ok = ok && (is_numeral(c[0]) || c[0] == CH_DASH);
		ok = ok && is_numeral(c[5]) && is_numeral(c[6]);
		ok = ok && is_numeral(c[8]) && is_numeral(c[9]);
		if (!ok)
			return r;
		yr = numeral(c[1]) * 100 + numeral(c[2]) * 10 + numeral(c[3]);
		if (c[0] == CH_DASH)
			yr = -yr;
		else
			yr += numeral(c[0]) * 1000;
		mon = numeral(c[5]) * 10 + numeral(c[6]);
		dd = numeral(c[8]) * 10 + numeral(c[9]);
		if (mon < 1 || mon > 12 || dd < 1 || dd > 31)
			return r;
		// March-based year, 400-year eras, floor division for negative years
		if (mon <= 2)
			yr--;
		era = (yr >= 0 ? yr : yr - 399) / 400;
		yoe = yr - era * 400;
		mp = (mon > 2) ? mon - 3 : mon + 9;
		doy = (153 * mp + 2) / 5 + dd - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = era * 146097 + doe - 719468;
		r.valid_res = 1'b1;
		r.day_number = days[22:0];
		r.epoch_nanos = days * NS_PER_DAY;
		r.overflow = (days > SAFE_DAYS || days < -SAFE_DAYS);
		return r;
	endfunction

	// Text fields from a string, padded with spaces
	function automatic idte_text_t text_from(input string s, input logic [7:0] len);
		idte_text_t t;
		t = '0;
		t.text_length = len;
		for (int i = 0; i < 10; i++)
			t[79 - 8 * i -: 8] = (i < s.len()) ? s[i] : 8'h20;
		return t;
	endfunction

	// Well-formed date with random content; some years near the overflow edges
	function automatic idte_text_t random_wellformed();
		int kind;
		int yr;
		string ys;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			ys = $sformatf("-%03d", $urandom_range(0, 999));
		end else if (kind < 4) begin
			case ($urandom_range(0, 3))
				0: yr = 1677;
				1: yr = 1678;
				2: yr = 2261;
				default: yr = 2262;
			endcase
			ys = $sformatf("%04d", yr);
		end else begin
			ys = $sformatf("%04d", $urandom_range(0, 9999));
		end
		return text_from($sformatf("%s-%02d-%02d", ys, $urandom_range(1, 12),
			$urandom_range(1, 31)), DATE_LEN);
	endfunction

	// A well-formed date broken in one place
	function automatic idte_text_t random_broken();
		idte_text_t t;
		int pos;
		int n;
		t = random_wellformed();
		case ($urandom_range(0, 5))
			0: t.text_length = 8'($urandom_range(0, 255));
			1: begin
				pos = $urandom_range(0, 9);
				t[79 - 8 * pos -: 8] = 8'($urandom_range(0, 255));
			end
			2: begin
				n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
				t.char_5 = CH_ZERO + 8'(n / 10);
				t.char_6 = CH_ZERO + 8'(n % 10);
			end
			3: begin
				n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(32, 99);
				t.char_8 = CH_ZERO + 8'(n / 10);
				t.char_9 = CH_ZERO + 8'(n % 10);
			end
			4: begin
				// minus sign inside month or day
				pos = ($urandom_range(0, 1) == 0) ? 5 : 8;
				t[79 - 8 * pos -: 8] = CH_DASH;
			end
			default: t[79 -: 8] = ($urandom_range(0, 1) == 0) ? 8'h2F : 8'h3A;
		endcase
		return t;
	endfunction

	// Random bytes; half of them keep the dashes so the digit checks get reached
	function automatic idte_text_t random_noise();
		idte_text_t t;
		t = idte_text_t'(88'({$urandom(), $urandom(), $urandom()}));
		if ($urandom_range(0, 1) == 0) begin
			t.text_length = DATE_LEN;
			t.char_4 = CH_DASH;
			t.char_7 = CH_DASH;
		end
		return t;
	endfunction

	function automatic idte_text_t random_mix();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return random_wellformed();
		if (r < 90)
			return random_broken();
		return random_noise();
	endfunction

	// One input transaction; the expectation is queued when it is accepted
	task automatic send_date(input idte_text_t t);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		{in_ch.text_length, in_ch.char_0, in_ch.char_1, in_ch.char_2, in_ch.char_3,
			in_ch.char_4, in_ch.char_5, in_ch.char_6, in_ch.char_7, in_ch.char_8,
			in_ch.char_9} <= t;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_conversions.insert(pending_conversions.size(), civil_epoch_of(t));
		dates_sent++;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Output side: ready drops for random stretches while idling is on
	initial begin
		out_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 99) < 25) begin
				out_ch.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		epoch_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_checked++;
			if (pending_conversions.size() == 0) begin
				report_mismatch("result with no pending date");
			end else begin
				want = pending_conversions[0];
				pending_conversions.delete(0);
				if (out_ch.valid_res !== want.valid_res)
					report_mismatch($sformatf("valid_res got %b want %b",
						out_ch.valid_res, want.valid_res));
				if (out_ch.day_number !== want.day_number)
					report_mismatch($sformatf("day_number got %0d want %0d",
						out_ch.day_number, want.day_number));
				if (out_ch.epoch_nanos !== want.epoch_nanos)
					report_mismatch($sformatf("epoch_nanos got %0d want %0d",
						out_ch.epoch_nanos, want.epoch_nanos));
				if (out_ch.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %b want %b",
						out_ch.overflow, want.overflow));
				if (want.valid_res)
					valid_seen++;
				if (want.overflow)
					overflow_seen++;
			end
		end
	end

	// Field extremes, calendar corners, overflow edges and each reject reason
	task automatic test_directed();
		string dates[$];
		idle_on = 1'b0;
		dates = '{"1970-01-01", "1969-12-31", "0000-03-01", "-000-01-01",
			"-999-01-01", "9999-12-31", "2000-02-29", "2262-04-11", "2262-04-12",
			"1677-09-21", "1677-09-20", "2023-02-31", "2024-00-10", "2024-13-10",
			"2024-01-00", "2024-01-32", "2024--1-05", "2024-01--5", "2024/01/05",
			"/999-01-01", ":999-01-01", "+970-01-01"};
		foreach (dates[i])
			send_date(text_from(dates[i], DATE_LEN));
		send_date(text_from("1970-01-01", 8'd9));
		send_date(text_from("1970-01-01", 8'd255));
		send_date(text_from("1970-01-01", 8'd0));
	endtask

	task automatic test_random_dates(input int n);
		idle_on = 1'b1;
		repeat (n)
			send_date(random_mix());
	endtask

	task automatic test_malformed(input int n);
		idle_on = 1'b1;
		repeat (n)
			send_date(($urandom_range(0, 1) == 0) ? random_broken() : random_noise());
	endtask

	// Full rate on both sides
	task automatic test_back_to_back(input int n);
		idle_on = 1'b0;
		repeat (n)
			send_date(random_mix());
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_conversions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b0;
		in_ch.valid = 1'b0;
		{in_ch.text_length, in_ch.char_0, in_ch.char_1, in_ch.char_2, in_ch.char_3,
			in_ch.char_4, in_ch.char_5, in_ch.char_6, in_ch.char_7, in_ch.char_8,
			in_ch.char_9} = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_dates(700);
		test_malformed(300);
		test_back_to_back(400);
		drain_results();

		$display("dates sent %0d, results checked %0d, mismatches %0d", dates_sent,
			results_checked, mismatch_count);
		$display("well-formed dates %0d, overflowed products %0d", valid_seen,
			overflow_seen);
		if (mismatch_count == 0)
			$display("[iso_date_to_epoch_nanos_top] OK");
		else
			$display("[iso_date_to_epoch_nanos_top] ERROR");
		$finish;
	end

endmodule
